[rtl/kmst_pkg.sv]
// ----------------------------------------------------------------------------
// kmst_pkg: shared types and constants of the Kruskal MST engine
// Sizes of the stores, the edge word, the front-to-back command and the
// state encoding of the back end.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_EDGES   = 4096;
  localparam int WEIGHT_BITS = 32;

  // Node index (zero based), node count, edge address and fill widths.
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = NODE_W + 1;
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int FILL_W  = EADDR_W + 1;
  localparam int COST_W  = 42;
  localparam int TAKEN_W = 10;

  typedef enum logic [1:0] {
    ST_CONNECTED = 2'd0,
    ST_OPEN      = 2'd1,
    ST_BAD       = 2'd2
  } status_e;

  // One stored edge: zero-based end nodes and the signed weight.
  typedef struct packed {
    logic [NODE_W-1:0]             a;
    logic [NODE_W-1:0]             b;
    logic signed [WEIGHT_BITS-1:0] w;
  } edge_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic  store;
    logic  close;
    logic  bad;
    edge_t edge_d;
  } cmd_t;

  // Union-find word: parent pointer and set size.
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [CNT_W-1:0]  size;
  } uf_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SRT_BLK,
    S_SRT_RD,
    S_SRT_WR,
    S_EDG_RD,
    S_EDG_CHK,
    S_FND_RD,
    S_FND_CHK,
    S_LINK_A,
    S_LINK_B,
    S_DONE
  } back_state_e;

endpackage

[rtl/kmst_front.sv]
// ----------------------------------------------------------------------------
// kmst_front: input classifier
// Checks each incoming beat against the node range and the store capacity
// and turns it into a store, drop or close command for the back end.
// ----------------------------------------------------------------------------
module kmst_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [10:0]             node_a_i,
  input  logic [10:0]             node_b_i,
  input  logic signed [31:0]      edge_weight_i,
  input  logic                    edge_present_i,
  input  logic                    last_edge_i,
  input  logic [kmst_pkg::CNT_W-1:0] node_cnt_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output kmst_pkg::cmd_t          cmd_o
);

  logic [kmst_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                        range_ok;
  logic                        store_full;
  logic [10:0]                 a_m1, b_m1;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Range check against the current node count and the store capacity.
  assign range_ok   = (node_a_i != 11'd0) && (node_a_i <= node_cnt_i) &&
                      (node_b_i != 11'd0) && (node_b_i <= node_cnt_i);
  assign store_full = fill_q >= kmst_pkg::FILL_W'(kmst_pkg::MAX_EDGES);
  assign a_m1       = node_a_i - 11'd1;
  assign b_m1       = node_b_i - 11'd1;

  always_comb begin
    cmd_o.store    = edge_present_i & range_ok & ~store_full;
    cmd_o.bad      = edge_present_i & ~(range_ok & ~store_full);
    cmd_o.close    = last_edge_i;
    cmd_o.edge_d.a = a_m1[kmst_pkg::NODE_W-1:0];
    cmd_o.edge_d.b = b_m1[kmst_pkg::NODE_W-1:0];
    cmd_o.edge_d.w = edge_weight_i;
  end

  // Local copy of the store fill, mirrors the back end in command order.
  always_comb begin
    fill_d = fill_q;
    if (push_o) begin
      if (last_edge_i) begin
        fill_d = '0;
      end else if (cmd_o.store) begin
        fill_d = fill_q + kmst_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

[rtl/kmst_queue.sv]
// ----------------------------------------------------------------------------
// kmst_queue: two-entry command queue
// Decouples the classifier from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module kmst_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kmst_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output kmst_pkg::cmd_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);

  kmst_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Payload slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[rtl/kmst_edge_ram.sv]
// ----------------------------------------------------------------------------
// kmst_edge_ram: edge memory
// One write port and two registered read ports, used as store and as one
// half of the ping-pong merge sort buffer.
// ----------------------------------------------------------------------------
module kmst_edge_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [kmst_pkg::EADDR_W-1:0] waddr_i,
  input  kmst_pkg::edge_t              wdata_i,
  input  logic [kmst_pkg::EADDR_W-1:0] raddr0_i,
  input  logic [kmst_pkg::EADDR_W-1:0] raddr1_i,
  output kmst_pkg::edge_t              rdata0_o,
  output kmst_pkg::edge_t              rdata1_o
);

  kmst_pkg::edge_t mem [kmst_pkg::MAX_EDGES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

[rtl/kmst_back.sv]
// ----------------------------------------------------------------------------
// kmst_back: edge store, sorter and union-find walker
// Stores edges from the queue, then on a close command resets the
// union-find table, merge-sorts the edges by weight and walks them.
// ----------------------------------------------------------------------------
module kmst_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [kmst_pkg::CNT_W-1:0]   node_cnt_i,
  input  kmst_pkg::cmd_t               cmd_i,
  input  logic                         q_empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [kmst_pkg::COST_W-1:0] total_cost_o,
  output logic [kmst_pkg::TAKEN_W-1:0] edges_taken_o,
  output logic [1:0]                   status_o
);

  localparam int FW = kmst_pkg::FILL_W;
  localparam int NW = kmst_pkg::NODE_W;
  localparam int CW = kmst_pkg::CNT_W;

  kmst_pkg::back_state_e state_q, state_d;

  logic [FW-1:0] fill_q, fill_d;
  logic          bad_q, bad_d;
  logic          src_q, src_d;
  logic [FW-1:0] width_q, width_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [FW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, idx_q, idx_d;
  logic [NW-1:0] clr_q, clr_d, r_q, r_d, ra_q, ra_d, rb_q, rb_d;
  logic [CW-1:0] sa_q, sa_d, sb_q, sb_d, comp_q, comp_d;
  logic          which_q, which_d;
  logic signed [kmst_pkg::WEIGHT_BITS-1:0] w_q, w_d;
  logic signed [kmst_pkg::COST_W-1:0]      cost_q, cost_d;
  logic [kmst_pkg::TAKEN_W-1:0]            taken_q, taken_d;

  // Edge memory ports.
  logic                         ram0_we, ram1_we;
  logic [kmst_pkg::EADDR_W-1:0] waddr, raddr0, raddr1;
  kmst_pkg::edge_t              wdata, r0d0, r0d1, r1d0, r1d1, rd0, rd1;

  // Union-find memory.
  kmst_pkg::uf_word_t uf_mem [kmst_pkg::MAX_NODES];
  kmst_pkg::uf_word_t uf_rd_q, uf_wdata;
  logic               uf_we;
  logic [NW-1:0]      uf_waddr, uf_raddr;

  // Merge and walk helpers.
  logic [FW:0]   mid_sum, hi_sum, width2;
  logic [FW-1:0] mid_c, hi_c, k_inc, idx_inc;
  logic          take_i;
  logic [NW-1:0] win, lose;
  logic [CW-1:0] lose_size;

  kmst_edge_ram u_ram0 (
    .clk_i    (clk_i),
    .we_i     (ram0_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (r0d0),
    .rdata1_o (r0d1)
  );

  kmst_edge_ram u_ram1 (
    .clk_i    (clk_i),
    .we_i     (ram1_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (r1d0),
    .rdata1_o (r1d1)
  );

  assign rd0 = src_q ? r1d0 : r0d0;
  assign rd1 = src_q ? r1d1 : r0d1;

  always_ff @(posedge clk_i) begin
    if (uf_we) begin
      uf_mem[uf_waddr] <= uf_wdata;
    end
    uf_rd_q <= uf_mem[uf_raddr];
  end

  // Block bounds of the current merge, clipped to the fill.
  assign mid_sum = {1'b0, lo_q} + {1'b0, width_q};
  assign mid_c   = (mid_sum > {1'b0, fill_q}) ? fill_q : mid_sum[FW-1:0];
  assign hi_sum  = {1'b0, mid_c} + {1'b0, width_q};
  assign hi_c    = (hi_sum > {1'b0, fill_q}) ? fill_q : hi_sum[FW-1:0];
  assign width2  = {width_q, 1'b0};
  assign k_inc   = k_q + FW'(1);
  assign idx_inc = idx_q + FW'(1);
  assign take_i  = (i_q < mid_q) && ((j_q >= hi_q) || (rd0.w <= rd1.w));

  // Union by size, the first root wins a tie.
  assign win       = (sa_q >= sb_q) ? ra_q : rb_q;
  assign lose      = (sa_q >= sb_q) ? rb_q : ra_q;
  assign lose_size = (sa_q >= sb_q) ? sb_q : sa_q;

  assign out_valid_o   = state_q == kmst_pkg::S_DONE;
  assign total_cost_o  = cost_q;
  assign edges_taken_o = taken_q;
  assign status_o      = bad_q ? kmst_pkg::ST_BAD :
                         (comp_q == CW'(1)) ? kmst_pkg::ST_CONNECTED : kmst_pkg::ST_OPEN;

  // Next state and datapath control.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    bad_d    = bad_q;
    src_d    = src_q;
    width_d  = width_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    hi_d     = hi_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    idx_d    = idx_q;
    clr_d    = clr_q;
    r_d      = r_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    sa_d     = sa_q;
    sb_d     = sb_q;
    comp_d   = comp_q;
    which_d  = which_q;
    w_d      = w_q;
    cost_d   = cost_q;
    taken_d  = taken_q;
    pop_o    = 1'b0;
    ram0_we  = 1'b0;
    ram1_we  = 1'b0;
    waddr    = fill_q[kmst_pkg::EADDR_W-1:0];
    wdata    = cmd_i.edge_d;
    raddr0   = i_q[kmst_pkg::EADDR_W-1:0];
    raddr1   = j_q[kmst_pkg::EADDR_W-1:0];
    uf_we    = 1'b0;
    uf_waddr = clr_q;
    uf_wdata = '{parent: clr_q, size: CW'(1)};
    uf_raddr = r_q;

    case (state_q)
      // Take commands: store edges, record drops, start on close.
      kmst_pkg::S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.store) begin
            ram0_we = 1'b1;
            fill_d  = fill_q + FW'(1);
          end
          if (cmd_i.bad) begin
            bad_d = 1'b1;
          end
          if (cmd_i.close) begin
            src_d   = 1'b0;
            clr_d   = '0;
            comp_d  = node_cnt_i;
            cost_d  = '0;
            taken_d = '0;
            state_d = kmst_pkg::S_CLEAR;
          end
        end
      end

      // Every node becomes its own root of size one.
      kmst_pkg::S_CLEAR: begin
        uf_we = 1'b1;
        clr_d = clr_q + NW'(1);
        if (clr_q == NW'(kmst_pkg::MAX_NODES - 1)) begin
          width_d = FW'(1);
          lo_d    = '0;
          idx_d   = '0;
          if (fill_q == '0) begin
            state_d = kmst_pkg::S_DONE;
          end else if (fill_q == FW'(1)) begin
            state_d = kmst_pkg::S_EDG_RD;
          end else begin
            state_d = kmst_pkg::S_SRT_BLK;
          end
        end
      end

      // Set up one pair of runs.
      kmst_pkg::S_SRT_BLK: begin
        mid_d   = mid_c;
        hi_d    = hi_c;
        i_d     = lo_q;
        j_d     = mid_c;
        k_d     = lo_q;
        state_d = kmst_pkg::S_SRT_RD;
      end

      kmst_pkg::S_SRT_RD: begin
        state_d = kmst_pkg::S_SRT_WR;
      end

      // Move the smaller head into the other buffer.
      kmst_pkg::S_SRT_WR: begin
        ram0_we = src_q;
        ram1_we = ~src_q;
        waddr   = k_q[kmst_pkg::EADDR_W-1:0];
        wdata   = take_i ? rd0 : rd1;
        if (take_i) begin
          i_d = i_q + FW'(1);
        end else begin
          j_d = j_q + FW'(1);
        end
        k_d     = k_inc;
        state_d = kmst_pkg::S_SRT_RD;
        if (k_inc == hi_q) begin
          lo_d    = hi_q;
          state_d = kmst_pkg::S_SRT_BLK;
          if (hi_q >= fill_q) begin
            width_d = width2[FW-1:0];
            src_d   = ~src_q;
            lo_d    = '0;
            if (width2 >= {1'b0, fill_q}) begin
              idx_d   = '0;
              state_d = kmst_pkg::S_EDG_RD;
            end
          end
        end
      end

      kmst_pkg::S_EDG_RD: begin
        raddr0  = idx_q[kmst_pkg::EADDR_W-1:0];
        state_d = kmst_pkg::S_EDG_CHK;
      end

      // Skip edges that no longer fit the node count and mark the graph bad.
      kmst_pkg::S_EDG_CHK: begin
        if (({1'b0, rd0.a} >= node_cnt_i) || ({1'b0, rd0.b} >= node_cnt_i)) begin
          bad_d   = 1'b1;
          idx_d   = idx_inc;
          state_d = (idx_inc == fill_q) ? kmst_pkg::S_DONE : kmst_pkg::S_EDG_RD;
        end else begin
          w_d     = rd0.w;
          r_d     = rd0.a;
          rb_d    = rd0.b;
          which_d = 1'b0;
          state_d = kmst_pkg::S_FND_RD;
        end
      end

      kmst_pkg::S_FND_RD: begin
        state_d = kmst_pkg::S_FND_CHK;
      end

      // Follow parent pointers up to the root.
      kmst_pkg::S_FND_CHK: begin
        state_d = kmst_pkg::S_FND_RD;
        if (uf_rd_q.parent == r_q) begin
          if (!which_q) begin
            ra_d    = r_q;
            sa_d    = uf_rd_q.size;
            r_d     = rb_q;
            which_d = 1'b1;
          end else begin
            rb_d    = r_q;
            sb_d    = uf_rd_q.size;
            state_d = kmst_pkg::S_LINK_A;
          end
        end else begin
          r_d = uf_rd_q.parent;
        end
      end

      // Hang the smaller root below the larger one, or skip the edge when both ends share a root.
      kmst_pkg::S_LINK_A: begin
        if (ra_q == rb_q) begin
          idx_d   = idx_inc;
          state_d = (idx_inc == fill_q) ? kmst_pkg::S_DONE : kmst_pkg::S_EDG_RD;
        end else begin
          uf_we    = 1'b1;
          uf_waddr = lose;
          uf_wdata = '{parent: win, size: lose_size};
          state_d  = kmst_pkg::S_LINK_B;
        end
      end

      kmst_pkg::S_LINK_B: begin
        uf_we    = 1'b1;
        uf_waddr = win;
        uf_wdata = '{parent: win, size: sa_q + sb_q};
        cost_d   = cost_q + kmst_pkg::COST_W'(w_q);
        taken_d  = taken_q + kmst_pkg::TAKEN_W'(1);
        comp_d   = comp_q - CW'(1);
        idx_d    = idx_inc;
        state_d  = (idx_inc == fill_q) ? kmst_pkg::S_DONE : kmst_pkg::S_EDG_RD;
      end

      // Hold the result until it is taken, then clear the stores.
      kmst_pkg::S_DONE: begin
        if (!out_stall_i) begin
          fill_d  = '0;
          bad_d   = 1'b0;
          state_d = kmst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kmst_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmst_pkg::S_IDLE;
      fill_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bad_q   <= bad_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    width_q <= width_d;
    lo_q    <= lo_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    clr_q   <= clr_d;
    r_q     <= r_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    comp_q  <= comp_d;
    which_q <= which_d;
    w_q     <= w_d;
    cost_q  <= cost_d;
    taken_q <= taken_d;
  end

endmodule

[rtl/kruskal_mst_engine_top.sv]
// Edges load at one beat per cycle while the back end is idle; the two-entry queue then stalls.
// After the last beat the back end takes the close, sets up the union-find table and runs
// ceil(log2 E) merge sort passes, each setting up every pair of runs and moving every edge.
// Per edge: fetch and check, walk each find path node by node to its root, then skip the
// edge when both roots match or link them. One graph at a time; the result waits.
// Reset clears the control state and sets the node count to one.
// ----------------------------------------------------------------------------
// kruskal_mst_engine_top: minimum spanning tree cost engine
// Classifier, command queue and sort / union-find back end with the
// node count configuration register.
// ----------------------------------------------------------------------------
module kruskal_mst_engine_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data_i,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [10:0]  node_a_i,
  input  logic [10:0]  node_b_i,
  input  logic signed [31:0] edge_weight_i,
  input  logic         edge_present_i,
  input  logic         last_edge_i,
  output logic         out_valid,
  input  logic         out_stall,
  output logic signed [41:0] total_cost_o,
  output logic [9:0]   edges_taken_o,
  output logic [1:0]   status_o
);

  logic [10:0]                     node_count_q;
  logic [kmst_pkg::CNT_W-1:0]      node_eff;
  logic                            q_full, q_empty, push, pop;
  kmst_pkg::cmd_t                  push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  // Node count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1;
    end else if (cfg_valid) begin
      node_count_q <= cfg_data_i;
    end
  end

  // Zero acts as one, large counts saturate.
  assign node_eff = (node_count_q == 11'd0) ? kmst_pkg::CNT_W'(1) :
                    (node_count_q > 11'(kmst_pkg::MAX_NODES)) ?
                    kmst_pkg::CNT_W'(kmst_pkg::MAX_NODES) : node_count_q;

  kmst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .edge_weight_i  (edge_weight_i),
    .edge_present_i (edge_present_i),
    .last_edge_i    (last_edge_i),
    .node_cnt_i     (node_eff),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  kmst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  kmst_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .node_cnt_i    (node_eff),
    .cmd_i         (pop_cmd),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .total_cost_o  (total_cost_o),
    .edges_taken_o (edges_taken_o),
    .status_o      (status_o)
  );

endmodule

[tb/sv/tb_kruskal_mst_engine_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kruskal_mst_engine_top: self-checking bench of the MST cost engine
// Streams weighted edges graph by graph, with random gaps on the input and
// random stalls on the output, and compares every result with an in-bench Kruskal / union-find
// predictor that tracks the node count register, or with the table values for typed directed rows.
// ----------------------------------------------------------------------------
module tb_kruskal_mst_engine_top;

  typedef kmst_pkg::status_e status_e;
  localparam int      MAX_NODES    = kmst_pkg::MAX_NODES;
  localparam int      MAX_EDGES    = kmst_pkg::MAX_EDGES;
  localparam status_e ST_CONNECTED = kmst_pkg::ST_CONNECTED;
  localparam status_e ST_OPEN      = kmst_pkg::ST_OPEN;
  localparam status_e ST_BAD       = kmst_pkg::ST_BAD;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_ITEMS   = 1750;

  // One directed row: either a register write or an edge beat.
  typedef struct packed {
    logic        is_cfg;
    logic [10:0] cfg_val;
    logic [10:0] a;
    logic [10:0] b;
    logic [31:0] w;
    logic        present;
    logic        last;
    logic        typed;
    logic [41:0] cost;
    logic [9:0]  taken;
    status_e     st;
  } dir_row_t;

  typedef struct packed {
    logic [41:0] cost;
    logic [9:0]  taken;
    status_e     st;
  } mst_result_t;

  localparam int DIR_ROWS = 27;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 11'd0,    11'd0,    11'd0,    32'd0,        1'b0, 1'b1, 1'b1, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd1,    32'd5,        1'b1, 1'b1, 1'b1, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd0,    11'd1,    32'd7,        1'b1, 1'b1, 1'b1, 42'd0, 10'd0, ST_BAD},
    '{1'b0, 11'd0,    11'd2,    11'd1,    32'd7,        1'b1, 1'b1, 1'b1, 42'd0, 10'd0, ST_BAD},
    '{1'b0, 11'd0,    11'd2047, 11'd2047, 32'h80000000, 1'b1, 1'b1, 1'b1, 42'd0, 10'd0, ST_BAD},
    '{1'b1, 11'd0,    11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd0,    11'd0,    32'd0,        1'b0, 1'b1, 1'b1, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b1, 11'd2047, 11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd1024, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1024, 11'd2,    32'h80000000, 1'b1, 1'b1, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b1, 11'd4,    11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd2,    32'd10,       1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd2,    11'd3,    32'd10,       1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd3,    -32'sd3,      1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd3,    11'd4,    32'd7,        1'b1, 1'b1, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd2,    32'd1,        1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd2,    11'd1,    32'd1,        1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd3,    11'd4,    -32'sd1,      1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd4,    11'd3,    32'd2,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd3,    32'd0,        1'b1, 1'b1, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b1, 11'd3,    11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd2,    32'd4,        1'b1, 1'b1, 1'b1, 42'd4, 10'd1, ST_OPEN},
    '{1'b1, 11'd8,    11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd7,    11'd8,    32'd1,        1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd1,    11'd2,    32'd2,        1'b1, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b1, 11'd4,    11'd0,    11'd0,    32'd0,        1'b0, 1'b0, 1'b0, 42'd0, 10'd0, ST_CONNECTED},
    '{1'b0, 11'd0,    11'd0,    11'd0,    32'd0,        1'b0, 1'b1, 1'b1, 42'd2, 10'd1, ST_BAD}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [10:0]  cfg_data_i = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [10:0]  node_a_i = '0;
  logic [10:0]  node_b_i = '0;
  logic signed [31:0] edge_weight_i = '0;
  logic         edge_present_i = 1'b0;
  logic         last_edge_i = 1'b0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic signed [41:0] total_cost_o;
  logic [9:0]   edges_taken_o;
  logic [1:0]   status_o;

  kruskal_mst_engine_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data_i     (cfg_data_i),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .edge_weight_i  (edge_weight_i),
    .edge_present_i (edge_present_i),
    .last_edge_i    (last_edge_i),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .total_cost_o   (total_cost_o),
    .edges_taken_o  (edges_taken_o),
    .status_o       (status_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: register, stored edge keys and union-find tables.
  logic [10:0]       node_count_q = 11'd1;
  logic              bad_seen = 1'b0;
  longint unsigned   edge_keys[$];
  int                uf_parent [MAX_NODES];
  int                uf_size [MAX_NODES];
  mst_result_t       pending_results[$];
  int                err_cnt = 0;
  int                result_cnt = 0;
  int                graph_cnt = 0;
  int                item_cnt = 0;
  bit                calm = 1'b0;
  int                quiet_cycles = 0;

  function automatic int eff_nodes();
    if (node_count_q == 0) return 1;
    if (node_count_q > MAX_NODES) return MAX_NODES;
    return int'(node_count_q);
  endfunction

  // Root lookup with path compression.
  function automatic int uf_root(int x);
    int r;
    int nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[x] != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  // Kruskal over the stored edges; edges sort by weight, then first, then second node.
  function automatic mst_result_t mst_close();
    mst_result_t res;
    int n, comps, ra, rb, ea, eb;
    logic signed [31:0] w;
    n = eff_nodes();
    comps = n;
    res.cost = '0;
    res.taken = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      uf_parent[i] = i;
      uf_size[i] = 1;
    end
    edge_keys.sort();
    foreach (edge_keys[k]) begin
      w = edge_keys[k][51:20] ^ 32'h80000000;
      ea = int'(edge_keys[k][19:10]);
      eb = int'(edge_keys[k][9:0]);
      if (ea >= n || eb >= n) begin
        bad_seen = 1'b1;
        continue;
      end
      ra = uf_root(ea);
      rb = uf_root(eb);
      if (ra == rb) continue;
      if (uf_size[ra] >= uf_size[rb]) begin
        uf_parent[rb] = ra;
        uf_size[ra] += uf_size[rb];
      end else begin
        uf_parent[ra] = rb;
        uf_size[rb] += uf_size[ra];
      end
      comps--;
      res.taken = res.taken + 10'd1;
      res.cost = res.cost + {{10{w[31]}}, w};
    end
    if (bad_seen) res.st = ST_BAD;
    else res.st = (comps == 1) ? ST_CONNECTED : ST_OPEN;
    edge_keys.delete();
    bad_seen = 1'b0;
    return res;
  endfunction

  // Updates the shadow for one accepted beat; returns 1 when a result is due.
  function automatic bit mst_accept(logic [10:0] a, logic [10:0] b, logic [31:0] w,
                                    logic present, logic last, output mst_result_t res);
    int n;
    n = eff_nodes();
    if (present) begin
      if (a < 1 || a > n || b < 1 || b > n || edge_keys.size() >= MAX_EDGES)
        bad_seen = 1'b1;
      else
        edge_keys.push_back({12'd0, w ^ 32'h80000000, 10'(a - 1), 10'(b - 1)});
    end
    if (!last) return 1'b0;
    res = mst_close();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: alternating stall and ready stretches of random length.
  int stall_hold = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ~out_stall;
      stall_hold <= pick_gap();
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      result_cnt <= result_cnt + 1;
      if (pending_results.size() == 0) begin
        $error("result with no graph closed: cost %0d taken %0d status %0d",
               total_cost_o, edges_taken_o, status_o);
        err_cnt++;
      end else begin
        mst_result_t exp_r;
        exp_r = pending_results.pop_front();
        if (total_cost_o !== exp_r.cost) begin
          $error("total_cost: expected %0d, got %0d", $signed(exp_r.cost), total_cost_o);
          err_cnt++;
        end
        if (edges_taken_o !== exp_r.taken) begin
          $error("edges_taken: expected %0d, got %0d", exp_r.taken, edges_taken_o);
          err_cnt++;
        end
        if (status_o !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one edge beat after a random gap and updates the shadow on acceptance.
  task automatic send_beat(logic [10:0] a, logic [10:0] b, logic [31:0] w,
                           logic present, logic last, logic typed, mst_result_t typed_r);
    int gap;
    mst_result_t pred;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    node_a_i <= a;
    node_b_i <= b;
    edge_weight_i <= w;
    edge_present_i <= present;
    last_edge_i <= last;
    do @(posedge clk_i); while (in_stall);
    item_cnt++;
    if (mst_accept(a, b, w, present, last, pred)) begin
      graph_cnt++;
      pending_results.push_back(typed ? typed_r : pred);
    end
  endtask

  // Holds the input until every result is back and the back end has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [10:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_count_q = value;
  endtask

  function automatic logic [10:0] pick_node(int n);
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'($urandom_range(0, 2047));
    if (r == 2 && n < 2047) return 11'(n + 1);
    return 11'($urandom_range(1, n));
  endfunction

  // Stimulus.
  initial begin
    mst_result_t none_r;
    mst_result_t typed_r;
    int n, len, r;
    logic [10:0] na, nb;
    logic [31:0] w;
    logic present;
    none_r = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_node_count(dir_rows[i].cfg_val);
      end else begin
        typed_r.cost = dir_rows[i].cost;
        typed_r.taken = dir_rows[i].taken;
        typed_r.st = dir_rows[i].st;
        send_beat(dir_rows[i].a, dir_rows[i].b, dir_rows[i].w, dir_rows[i].present,
                  dir_rows[i].last, dir_rows[i].typed, typed_r);
      end
    end

    // Random graphs, now and then after a fresh node count.
    while (item_cnt < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0: write_node_count(11'd0);
          1: write_node_count(11'd1);
          2: write_node_count(11'd1024);
          3: write_node_count(11'($urandom_range(1025, 2047)));
          4: write_node_count(11'($urandom_range(17, 1024)));
          default: write_node_count(11'($urandom_range(2, 16)));
        endcase
      end
      n = eff_nodes();
      len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        na = pick_node(n);
        nb = ($urandom_range(0, 9) == 0) ? na : pick_node(n);
        if ($urandom_range(0, 1)) w = $urandom();
        else w = 32'($urandom_range(0, 8)) - 32'd4;
        present = ($urandom_range(0, 9) != 0);
        send_beat(na, nb, w, present, k == len - 1, 1'b0, none_r);
      end
    end

    calm = 1'b0;
    drain();
    $display("%0d edge beats in %0d graphs, %0d results checked, node counts 0..2047",
             item_cnt, graph_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
